>>> src/wlpm_pkg.sv
// Shared types and constants for the windowed latency percentile monitor.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package wlpm_pkg;

    // default sizing
    localparam int RING_DEPTH_DEF    = 1024;
    localparam int VERSION_SLOTS_DEF = 8;

    // fixed field widths
    localparam int OP_W     = 1;
    localparam int SLOT_IN_W = 3;
    localparam int STAMP_W  = 48;
    localparam int LAT_W    = 32;
    localparam int WIN_W    = 20;
    localparam int CAP_W    = 11;
    localparam int CNT_OUT_W = 11;
    localparam int FRAC_W   = 17;

    // p99 rank step: one extra sample above the rank per started hundred
    localparam int TAIL_STEP = 100;
    localparam int MS_PER_S  = 1000;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    typedef enum logic [0:0] {
        OP_RECORD = 1'b0,
        OP_QUERY  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DIV,
        S_OUT
    } t_state;

    // link between neighboring cells of the top-k chain
    typedef struct packed {
        logic             take;
        logic             valid;
        logic [LAT_W-1:0] value;
    } t_cell_link;

endpackage

>>> src/wlpm_cell.sv
// One cell of the descending top-k chain: holds one latency and its valid bit.
// Depends on wlpm_pkg.
`timescale 1ns / 1ps

module wlpm_cell (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_ins_valid,
    input  logic [wlpm_pkg::LAT_W-1:0] i_ins_value,
    input  wlpm_pkg::t_cell_link     i_left,
    output wlpm_pkg::t_cell_link     o_link
);
    import wlpm_pkg::*;

    logic             r_valid;
    logic [LAT_W-1:0] r_value;
    logic             take;

    // take the new beat when empty or when it beats the held value
    assign take = i_ins_valid && (!r_valid || (i_ins_value > r_value));

    assign o_link.take  = take;
    assign o_link.valid = r_valid;
    assign o_link.value = r_value;

    // hold, or shift in from the left neighbor, or insert here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (take) begin
            if (i_left.take) begin
                r_valid <= i_left.valid;
            end else begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_value <= i_left.take ? i_left.value : i_ins_value;
        end
    end

endmodule

>>> src/wlpm_topk_chain.sv
// Row of wlpm_cell keeping the largest latencies of a walk in descending order.
// Depends on wlpm_pkg and wlpm_cell.
`timescale 1ns / 1ps

module wlpm_topk_chain #(
    parameter int CELLS = 11,
    parameter int SEL_W = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_ins_valid,
    input  logic [wlpm_pkg::LAT_W-1:0] i_ins_value,
    input  logic [SEL_W-1:0]           i_sel,
    output logic [wlpm_pkg::LAT_W-1:0] o_sel_value
);
    import wlpm_pkg::*;

    t_cell_link links [CELLS+1];

    // nothing shifts into the head of the row
    assign links[0] = '0;

    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        wlpm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (i_clear),
            .i_ins_valid (i_ins_valid),
            .i_ins_value (i_ins_value),
            .i_left      (links[g]),
            .o_link      (links[g+1])
        );
    end

    // pick the cell at the requested rank from the top
    always_comb begin
        o_sel_value = '0;
        for (int k = 0; k < CELLS; k++) begin
            if (i_sel == SEL_W'(k)) begin
                o_sel_value = links[k+1].value;
            end
        end
    end

endmodule

>>> src/wlpm_div.sv
// Restoring divider, one quotient bit a cycle: (errors << 16) / count.
// Depends on wlpm_pkg; requires errors <= count.
`timescale 1ns / 1ps

module wlpm_div #(
    parameter int CNT_W = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [CNT_W-1:0]            i_errors,
    input  logic [CNT_W-1:0]            i_count,
    output logic                        o_done,
    output logic [wlpm_pkg::FRAC_W-1:0] o_quot
);
    import wlpm_pkg::*;

    localparam int STEP_W = $clog2(FRAC_W + 1);

    logic [CNT_W:0]    r_rem;
    logic [CNT_W-1:0]  r_den;
    logic [FRAC_W-1:0] r_quot;
    logic [STEP_W-1:0] r_steps;
    logic              r_busy;
    logic [CNT_W:0]    trial;
    logic              fits;

    // first step compares the raw numerator, later ones the doubled remainder
    assign trial = (r_steps == STEP_W'(FRAC_W)) ? r_rem : {r_rem[CNT_W-1:0], 1'b0};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_steps <= '0;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_steps <= STEP_W'(FRAC_W);
            end else if (r_busy) begin
                r_steps <= r_steps - 1'b1;
                if (r_steps == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    // advance one quotient bit
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_errors};
            r_den  <= i_count;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? (trial - {1'b0, r_den}) : trial;
            r_quot <= {r_quot[FRAC_W-2:0], fits};
        end
    end

    assign o_quot = r_quot;

endmodule

>>> src/windowed_latency_percentile_monitor_core.sv
// Top level of the windowed latency percentile monitor: sample memory, walk
// control, top-k chain and error-fraction divider. Depends on wlpm_pkg,
// wlpm_topk_chain and wlpm_div.
//
// Usage: drive the item fields and raise start; the item is taken at a clock
// edge with start high and busy low. A record beat writes one sample to the
// ring of its slot in that cycle and leaves busy low, so records can follow
// back to back, one a cycle. A query raises busy and walks the slot from
// newest to oldest, one memory read issued a cycle, each read checked against
// the cutoff in the cycle after its issue; a walk that stops at an old sample
// drops the one read already in flight. The 17-step divider starts right
// after the walk (skipped when nothing was passed), and the result is shown
// for exactly one cycle with o_result_valid. Busy stays high through the
// walk, any divide and the result beat; the walk reads through a single
// memory read port. The receiver cannot stall; the result beat is dropped
// if not taken in that cycle. Write ring_capacity through i_cfg_we only
// while busy is low. Synchronous reset clears ring pointers, fill levels and
// sets capacity to 1024; sample memory contents are not cleared.
`timescale 1ns / 1ps

module windowed_latency_percentile_monitor_core #(
    parameter int RING_DEPTH    = wlpm_pkg::RING_DEPTH_DEF,
    parameter int VERSION_SLOTS = wlpm_pkg::VERSION_SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cfg_we,
    input  logic [wlpm_pkg::CAP_W-1:0]     i_cfg_wdata,
    input  logic [wlpm_pkg::OP_W-1:0]      i_opcode,
    input  logic [wlpm_pkg::SLOT_IN_W-1:0] i_version_slot,
    input  logic [wlpm_pkg::STAMP_W-1:0]   i_sample_time_ms,
    input  logic [wlpm_pkg::LAT_W-1:0]     i_latency_value,
    input  logic                           i_failed_flag,
    input  logic [wlpm_pkg::STAMP_W-1:0]   i_query_now_ms,
    input  logic [wlpm_pkg::WIN_W-1:0]     i_window_seconds,
    output logic                           o_result_valid,
    output logic [wlpm_pkg::CNT_OUT_W-1:0] o_window_count,
    output logic [wlpm_pkg::FRAC_W-1:0]    o_error_fraction,
    output logic [wlpm_pkg::LAT_W-1:0]     o_tail_latency
);
    import wlpm_pkg::*;

    localparam int POS_W   = $clog2(RING_DEPTH);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int SLOT_W  = (VERSION_SLOTS > 1) ? $clog2(VERSION_SLOTS) : 1;
    localparam int MEM_D   = VERSION_SLOTS * RING_DEPTH;
    localparam int ADDR_W  = $clog2(MEM_D);
    localparam int CELLS   = (RING_DEPTH + TAIL_STEP - 1) / TAIL_STEP;
    localparam int SEL_W   = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int MOD_W   = $clog2(TAIL_STEP);
    localparam int WMS_W   = WIN_W + $clog2(MS_PER_S);

    // sample memory
    logic [STAMP_W-1:0] r_stamp_mem [MEM_D];
    logic [LAT_W-1:0]   r_lat_mem   [MEM_D];
    logic               r_err_mem   [MEM_D];

    // per-slot ring state
    logic [POS_W-1:0]  r_head [VERSION_SLOTS];
    logic [FILL_W-1:0] r_fill [VERSION_SLOTS];
    logic [CAP_W-1:0]  r_cap;

    t_state r_state, n_state;

    logic               accept;
    logic               slot_ok;
    logic [SLOT_W-1:0]  in_slot;
    logic [FILL_W-1:0]  eff_cap;
    logic               cap_ok;
    logic [POS_W-1:0]   rec_pos;
    logic [ADDR_W-1:0]  wr_addr;

    logic [SLOT_W-1:0]  r_slot;
    logic [POS_W-1:0]   r_pos;
    logic [FILL_W-1:0]  r_left;
    logic               r_stop;
    logic [STAMP_W-1:0] r_now;
    logic [WMS_W-1:0]   r_win_ms;
    logic               r_rd_valid;
    logic [STAMP_W-1:0] r_rd_stamp;
    logic [LAT_W-1:0]   r_rd_lat;
    logic               r_rd_err;
    logic [FILL_W-1:0]  r_n;
    logic [FILL_W-1:0]  r_errs;
    logic [MOD_W-1:0]   r_mod;
    logic [SEL_W-1:0]   r_sel;
    logic [FRAC_W-1:0]  r_frac;
    logic [LAT_W-1:0]   r_tail;

    logic               issue;
    logic [POS_W-1:0]   prev_pos;
    logic [ADDR_W-1:0]  rd_addr;
    logic               too_old;
    logic               ins;
    logic               walk_done;
    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  div_quot;
    logic [LAT_W-1:0]   sel_value;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = (32'(i_version_slot) < VERSION_SLOTS);
    assign in_slot = SLOT_W'(i_version_slot);

    // clamp capacity: zero or too large means full ring depth
    assign cap_ok  = (r_cap != '0) && (32'(r_cap) <= RING_DEPTH);
    assign eff_cap = cap_ok ? FILL_W'(r_cap) : FILL_W'(RING_DEPTH);
    assign rec_pos = r_head[in_slot];
    assign wr_addr = ADDR_W'(32'(in_slot) * RING_DEPTH + 32'(rec_pos));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // record: advance head, grow fill up to capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < VERSION_SLOTS; s++) begin
                r_head[s] <= '0;
                r_fill[s] <= '0;
            end
        end else if (accept && i_opcode == OP_RECORD && slot_ok) begin
            r_head[in_slot] <= (32'(rec_pos) == RING_DEPTH - 1) ? '0 : rec_pos + 1'b1;
            if (r_fill[in_slot] < eff_cap && 32'(r_fill[in_slot]) < RING_DEPTH) begin
                r_fill[in_slot] <= r_fill[in_slot] + 1'b1;
            end
        end
    end

    // walk address: step back one entry each issue
    assign issue    = (r_state == S_WALK) && (r_left != '0) && !r_stop;
    assign prev_pos = (r_pos == '0) ? POS_W'(RING_DEPTH - 1) : r_pos - 1'b1;
    assign rd_addr  = ADDR_W'(32'(r_slot) * RING_DEPTH + 32'(prev_pos));

    always_ff @(posedge i_clk) begin
        if (accept && i_opcode == OP_RECORD && slot_ok) begin
            r_stamp_mem[wr_addr] <= i_sample_time_ms;
            r_lat_mem[wr_addr]   <= i_latency_value;
            r_err_mem[wr_addr]   <= i_failed_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_stamp <= r_stamp_mem[rd_addr];
        r_rd_lat   <= r_lat_mem[rd_addr];
        r_rd_err   <= r_err_mem[rd_addr];
    end

    // evaluate the read beat against the cutoff
    assign too_old   = ({1'b0, r_rd_stamp} + (STAMP_W+1)'(r_win_ms)) < {1'b0, r_now};
    assign ins       = r_rd_valid && !r_stop && !too_old;
    assign walk_done = (r_state == S_WALK) && ((r_left == '0) || r_stop) && !r_rd_valid;
    assign div_start = walk_done && (r_n != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_stop     <= 1'b0;
            r_left     <= '0;
            r_n        <= '0;
            r_errs     <= '0;
            r_mod      <= '0;
            r_sel      <= '0;
        end else if (accept && i_opcode == OP_QUERY) begin
            r_rd_valid <= 1'b0;
            r_stop     <= 1'b0;
            r_left     <= slot_ok ? r_fill[in_slot] : '0;
            r_n        <= '0;
            r_errs     <= '0;
            r_mod      <= '0;
            r_sel      <= '0;
        end else begin
            r_rd_valid <= issue;
            if (issue) begin
                r_left <= r_left - 1'b1;
            end
            if (r_rd_valid && too_old) begin
                r_stop <= 1'b1;
            end
            if (ins) begin
                r_n    <= r_n + 1'b1;
                r_errs <= r_errs + FILL_W'(r_rd_err);
                // rank offset from the top is (n-1)/100
                if (r_n != '0) begin
                    if (32'(r_mod) == TAIL_STEP - 1) begin
                        r_mod <= '0;
                        r_sel <= r_sel + 1'b1;
                    end else begin
                        r_mod <= r_mod + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_opcode == OP_QUERY) begin
            r_slot   <= in_slot;
            r_pos    <= rec_pos;
            r_now    <= i_query_now_ms;
            r_win_ms <= WMS_W'(i_window_seconds) * WMS_W'(MS_PER_S);
        end else if (issue) begin
            r_pos <= prev_pos;
        end
    end

    wlpm_topk_chain #(
        .CELLS (CELLS),
        .SEL_W (SEL_W)
    ) u_chain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (accept && i_opcode == OP_QUERY),
        .i_ins_valid (ins),
        .i_ins_value (r_rd_lat),
        .i_sel       (r_sel),
        .o_sel_value (sel_value)
    );

    wlpm_div #(
        .CNT_W (FILL_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_errors (r_errs),
        .i_count  (r_n),
        .o_done   (div_done),
        .o_quot   (div_quot)
    );

    // latch result fields
    always_ff @(posedge i_clk) begin
        if (walk_done) begin
            r_tail <= (r_n == '0) ? '0 : sel_value;
            r_frac <= '0;
        end else if (div_done) begin
            r_frac <= div_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_opcode == OP_QUERY) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (walk_done) begin
                    n_state = (r_n == '0) ? S_OUT : S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_result_valid   = (r_state == S_OUT);
    assign o_window_count   = CNT_OUT_W'(r_n);
    assign o_error_fraction = r_frac;
    assign o_tail_latency   = r_tail;

    a_out_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !busy)
        else $error("result beat not followed by idle");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_opcode == OP_QUERY) |=> (busy && r_n == '0))
        else $error("query not started cleanly");

    a_errs_le_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_errs <= r_n)
        else $error("error count exceeds sample count");

    a_no_insert_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop && busy) |=> $stable(r_n))
        else $error("sample counted after walk stop");

endmodule

>>> bench/windowed_latency_percentile_monitor_core_tb.sv
// Self-checking bench for windowed_latency_percentile_monitor_core: directed
// and random record/query beats, checked against a scoreboard with its own ring model.
// Depends on wlpm_pkg and the core RTL.
`timescale 1ns / 1ps

module windowed_latency_percentile_monitor_core_tb;
    import wlpm_pkg::*;

    localparam int DEPTH  = 1024;
    localparam int SLOTS  = 8;
    localparam int PEND_D = 16;

    typedef struct {
        t_opcode              op;
        logic [SLOT_IN_W-1:0] slot;
        logic [STAMP_W-1:0]   stamp;
        logic [LAT_W-1:0]     lat;
        logic                 failed;
        logic [STAMP_W-1:0]   now_ms;
        logic [WIN_W-1:0]     win_s;
    } t_beat;

    typedef struct {
        logic [CNT_OUT_W-1:0] count;
        logic [FRAC_W-1:0]    frac;
        logic [LAT_W-1:0]     tail;
    } t_stats;

    // Ring model per slot plus a small ring of pending window stats
    class latency_scoreboard;
        logic [STAMP_W-1:0] stamp_mem [SLOTS][DEPTH];
        logic [LAT_W-1:0]   lat_mem [SLOTS][DEPTH];
        logic               err_mem [SLOTS][DEPTH];
        int unsigned        head [SLOTS];
        int unsigned        fill [SLOTS];
        logic [CAP_W-1:0]   capacity;
        t_stats             pend [PEND_D];
        int unsigned        pend_wr;
        int unsigned        pend_rd;
        int                 mismatches;

        function new();
            capacity    = CAP_RESET;
            mismatches  = 0;
            pend_wr     = 0;
            pend_rd     = 0;
            foreach (head[i]) begin
                head[i] = 0;
                fill[i] = 0;
            end
        endfunction

        function int unsigned outstanding();
            return pend_wr - pend_rd;
        endfunction

        function void note_beat(t_beat b);
            int unsigned       s, pos, cap_eff, n, errs, rank;
            longint unsigned   win_ms;
            logic [LAT_W-1:0]  gath [DEPTH];
            logic [LAT_W-1:0]  lats [];
            t_stats            st;
            s = b.slot;
            cap_eff = (capacity == 0 || capacity > DEPTH) ? DEPTH : capacity;
            if (b.op == OP_RECORD) begin
                pos = head[s];
                stamp_mem[s][pos] = b.stamp;
                lat_mem[s][pos]   = b.lat;
                err_mem[s][pos]   = b.failed;
                head[s] = (pos + 1) % DEPTH;
                if (fill[s] < cap_eff) fill[s]++;
                return;
            end
            // walk newest to oldest, stop at first sample before the cutoff
            win_ms = longint'(b.win_s) * MS_PER_S;
            pos = head[s];
            n = 0;
            errs = 0;
            for (int k = 0; k < fill[s]; k++) begin
                pos = (pos == 0) ? DEPTH - 1 : pos - 1;
                if (longint'(stamp_mem[s][pos]) + win_ms < longint'(b.now_ms)) break;
                gath[n] = lat_mem[s][pos];
                errs += 32'(err_mem[s][pos]);
                n++;
            end
            st = '{count: '0, frac: '0, tail: '0};
            if (n != 0) begin
                lats = new[n];
                for (int i = 0; i < n; i++) lats[i] = gath[i];
                lats.sort();
                rank = 32'((longint'(n) * 99) / 100);
                if (rank >= n) rank = n - 1;
                st.count = CNT_OUT_W'(n);
                st.frac  = FRAC_W'((longint'(errs) << 16) / n);
                st.tail  = lats[rank];
            end
            pend[pend_wr % PEND_D] = st;
            pend_wr++;
        endfunction

        function void check_stats(t_stats got);
            t_stats want;
            if (outstanding() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result beat cnt=%0d frac=%0d tail=%0d",
                             got.count, got.frac, got.tail);
                return;
            end
            want = pend[pend_rd % PEND_D];
            pend_rd++;
            if (got.count !== want.count || got.frac !== want.frac ||
                    got.tail !== want.tail) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: stats exp cnt=%0d frac=%0d tail=%0d ",
                              "got cnt=%0d frac=%0d tail=%0d"},
                             want.count, want.frac, want.tail,
                             got.count, got.frac, got.tail);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 i_cfg_we = 1'b0;
    logic [CAP_W-1:0]     i_cfg_wdata = '0;
    logic [OP_W-1:0]      i_opcode = '0;
    logic [SLOT_IN_W-1:0] i_version_slot = '0;
    logic [STAMP_W-1:0]   i_sample_time_ms = '0;
    logic [LAT_W-1:0]     i_latency_value = '0;
    logic                 i_failed_flag = 1'b0;
    logic [STAMP_W-1:0]   i_query_now_ms = '0;
    logic [WIN_W-1:0]     i_window_seconds = '0;
    logic                 o_result_valid;
    logic [CNT_OUT_W-1:0] o_window_count;
    logic [FRAC_W-1:0]    o_error_fraction;
    logic [LAT_W-1:0]     o_tail_latency;

    latency_scoreboard sb = new();
    longint unsigned   clock_ms = 1000;
    bit                no_gaps = 1'b0;

    windowed_latency_percentile_monitor_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_opcode         (i_opcode),
        .i_version_slot   (i_version_slot),
        .i_sample_time_ms (i_sample_time_ms),
        .i_latency_value  (i_latency_value),
        .i_failed_flag    (i_failed_flag),
        .i_query_now_ms   (i_query_now_ms),
        .i_window_seconds (i_window_seconds),
        .o_result_valid   (o_result_valid),
        .o_window_count   (o_window_count),
        .o_error_fraction (o_error_fraction),
        .o_tail_latency   (o_tail_latency)
    );

    always #5 i_clk = ~i_clk;

    // Check result beats, then log accepted input beats
    always @(posedge i_clk) begin
        t_beat b;
        if (i_rst_n) begin
            if (o_result_valid)
                sb.check_stats('{count: o_window_count, frac: o_error_fraction,
                                 tail: o_tail_latency});
            if (start && !busy) begin
                b.op     = t_opcode'(i_opcode);
                b.slot   = i_version_slot;
                b.stamp  = i_sample_time_ms;
                b.lat    = i_latency_value;
                b.failed = i_failed_flag;
                b.now_ms = i_query_now_ms;
                b.win_s  = i_window_seconds;
                sb.note_beat(b);
            end
        end
    end

    // Drive one beat, hold until accepted; optional idle burst first
    task automatic send_beat(t_beat b);
        if (!no_gaps && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        start            = 1'b1;
        i_opcode         = b.op;
        i_version_slot   = b.slot;
        i_sample_time_ms = b.stamp;
        i_latency_value  = b.lat;
        i_failed_flag    = b.failed;
        i_query_now_ms   = b.now_ms;
        i_window_seconds = b.win_s;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
    endtask

    task automatic record(int slot, longint unsigned stamp, int unsigned lat, bit failed);
        t_beat b;
        b = '{op: OP_RECORD, slot: SLOT_IN_W'(slot), stamp: STAMP_W'(stamp), lat: lat,
              failed: failed, now_ms: STAMP_W'($urandom), win_s: WIN_W'($urandom)};
        send_beat(b);
    endtask

    task automatic query(int slot, longint unsigned now_ms, int unsigned win_s);
        t_beat b;
        b = '{op: OP_QUERY, slot: SLOT_IN_W'(slot), stamp: STAMP_W'({$urandom, $urandom}),
              lat: $urandom, failed: 1'($urandom), now_ms: STAMP_W'(now_ms),
              win_s: WIN_W'(win_s)};
        send_beat(b);
    endtask

    // Drain pending stats and let the block settle
    task automatic wait_quiet();
        @(negedge i_clk);
        start = 1'b0;
        while (sb.outstanding() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] value);
        wait_quiet();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(posedge i_clk);
        sb.capacity = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic random_beat();
        int unsigned     slot, sel;
        longint unsigned stamp, now_ms, win_s;
        slot = $urandom_range(0, SLOTS - 1);
        if ($urandom_range(0, 4) != 0) begin
            clock_ms += $urandom_range(0, 800);
            stamp = clock_ms - $urandom_range(0, 200);
            if ($urandom_range(0, 15) == 0) stamp = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
            record(slot, stamp, $urandom, $urandom_range(0, 3) == 0);
        end else begin
            sel = $urandom_range(0, 9);
            now_ms = clock_ms + $urandom_range(0, 20000);
            win_s  = $urandom_range(0, 30);
            if (sel == 0) win_s = $urandom_range(0, (1 << WIN_W) - 1);
            if (sel == 1) now_ms = {$urandom, $urandom} & 48'hFFFF_FFFF_FFFF;
            query(slot, now_ms, win_s);
        end
    endtask

    initial begin
        logic [CAP_W-1:0] caps [7];
        caps = '{11'd3, 11'd1, 11'd0, 11'd2047, 11'd64, 11'd1024, 11'd5};
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes, exact cutoff, empty slot, negative cutoff
        set_capacity(11'd1024);
        record(0, 0, 0, 0);
        record(0, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1);
        query(0, 48'hFFFF_FFFF_FFFF, 0);
        query(0, 0, 0);
        query(1, 12345, 7);
        query(0, 5, 20'hF_FFFF);
        record(0, 2000, 32'h5555_AAAA, 1);
        query(0, 3000, 1);
        query(0, 3001, 1);
        for (int i = 0; i < 6; i++) record(2, 100 + i, i * 7 + 1, i[0]);
        query(2, 100, 0);
        // lower capacity below current fill
        set_capacity(11'd2);
        record(2, 200, 99, 1);
        query(2, 200, 1);
        set_capacity(11'd0);
        record(3, 50, 1, 0);
        query(3, 50, 0);

        for (int p = 0; p < 7; p++) begin
            set_capacity(caps[p]);
            if (p == 6) no_gaps = 1'b1;
            repeat (58) random_beat();
        end

        wait_quiet();
        if (sb.outstanding() != 0) sb.mismatches++;
        if (sb.mismatches == 0)
            $display("windowed_latency_percentile_monitor_core_tb: PASS");
        else
            $display("windowed_latency_percentile_monitor_core_tb: FAIL");
        $finish;
    end

    initial begin
        #20ms;
        $display("windowed_latency_percentile_monitor_core_tb: FAIL");
        $finish;
    end

endmodule
